// ===== src/otwmp_pkg.sv =====
package otwmp_pkg;

  localparam int MAX_ORDERS = 64;
  localparam int SLOT_W     = $clog2(MAX_ORDERS);
  localparam int CNT_W      = $clog2(MAX_ORDERS + 1);

  localparam int TIME_W  = 32;
  localparam int ID_W    = 32;
  localparam int PRICE_W = 32;
  localparam int SUM_W   = 64;

  // Input tdata: timestamp, order_id, price. Output tdata: book_nonempty,
  // highest_price, weighted_sum, exposed_time, padded to whole bytes.
  localparam int IN_DATA_W   = TIME_W + ID_W + PRICE_W;
  localparam int OUT_FIELD_W = 1 + PRICE_W + SUM_W + TIME_W;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_ERASE  = 1'b1
  } command_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_SCAN,
    S_COMMIT,
    S_RESP
  } state_e;

  typedef struct packed {
    logic capture;
    logic mul;
    logic acc;
    logic scan;
    logic commit;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } dp_sts_t;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic [ID_W-1:0]    id;
  } slot_t;

endpackage

// ===== src/order_table_time_weighted_max_price_core.sv =====
// A result item is offered after its input item passes the multiply, saturating add,
// scan of the 64 slot entries, commit and load; the load waits for a free output.
// A new item is accepted only once the previous result is in the output register.
// The output register lets the next item be accepted while a result waits.
// Reset (rst_ni, asynchronous, active low) empties the book and clears all sums.
module order_table_time_weighted_max_price_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // timestamp [31:0], order_id [63:32], price [95:64]
  input  logic [otwmp_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // command [0]
  input  logic                                 s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // book_nonempty [0], highest_price [32:1], weighted_sum [96:33],
  // exposed_time [128:97], zero padding above
  output logic [otwmp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // status [1:0]
  output logic [1:0]                           m_axis_tuser
);

  otwmp_pkg::dp_cmd_t cmd;
  otwmp_pkg::dp_sts_t sts;

  otwmp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  otwmp_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .in_command_i   (s_axis_tuser),
    .in_timestamp_i (s_axis_tdata[31:0]),
    .in_order_id_i  (s_axis_tdata[63:32]),
    .in_price_i     (s_axis_tdata[95:64]),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .out_data_o     (m_axis_tdata),
    .out_status_o   (m_axis_tuser)
  );

endmodule

// ===== src/otwmp_ctrl.sv =====
module otwmp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  otwmp_pkg::dp_sts_t  sts_i,
  output otwmp_pkg::dp_cmd_t  cmd_o
);

  otwmp_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= otwmp_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      otwmp_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = otwmp_pkg::S_MUL;
        end
      end
      otwmp_pkg::S_MUL:    state_d = otwmp_pkg::S_ADD;
      otwmp_pkg::S_ADD:    state_d = otwmp_pkg::S_SCAN;
      otwmp_pkg::S_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = otwmp_pkg::S_COMMIT;
        end
      end
      otwmp_pkg::S_COMMIT: state_d = otwmp_pkg::S_RESP;
      otwmp_pkg::S_RESP: begin
        if (sts_i.out_free) begin
          state_d = otwmp_pkg::S_IDLE;
        end
      end
      default:             state_d = otwmp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o     = (state_q == otwmp_pkg::S_IDLE);
    cmd_o          = '0;
    cmd_o.capture  = (state_q == otwmp_pkg::S_IDLE) && in_valid_i;
    cmd_o.mul      = (state_q == otwmp_pkg::S_MUL);
    cmd_o.acc      = (state_q == otwmp_pkg::S_ADD);
    cmd_o.scan     = (state_q == otwmp_pkg::S_SCAN);
    cmd_o.commit   = (state_q == otwmp_pkg::S_COMMIT);
    cmd_o.load_out = (state_q == otwmp_pkg::S_RESP) && sts_i.out_free;
  end

endmodule

// ===== src/otwmp_dp.sv =====
module otwmp_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  otwmp_pkg::dp_cmd_t                   cmd_i,
  output otwmp_pkg::dp_sts_t                   sts_o,
  input  logic                                 in_command_i,
  input  logic [otwmp_pkg::TIME_W-1:0]         in_timestamp_i,
  input  logic [otwmp_pkg::ID_W-1:0]           in_order_id_i,
  input  logic [otwmp_pkg::PRICE_W-1:0]        in_price_i,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic [otwmp_pkg::OUT_DATA_W-1:0]     out_data_o,
  output logic [1:0]                           out_status_o
);

  localparam int SlotW  = otwmp_pkg::SLOT_W;
  localparam int CntW   = otwmp_pkg::CNT_W;
  localparam int PriceW = otwmp_pkg::PRICE_W;
  localparam int TimeW  = otwmp_pkg::TIME_W;
  localparam int SumW   = otwmp_pkg::SUM_W;
  localparam int PadW   = otwmp_pkg::OUT_DATA_W - otwmp_pkg::OUT_FIELD_W;

  // Captured item.
  otwmp_pkg::command_e     command_q;
  logic [TimeW-1:0]        ts_q;
  logic [otwmp_pkg::ID_W-1:0] id_q;
  logic [PriceW-1:0]       price_q;

  // Book state.
  logic [otwmp_pkg::MAX_ORDERS-1:0] valid_q, valid_d;
  logic [CntW-1:0]         count_q, count_d;
  logic [PriceW-1:0]       max_q, max_d;
  logic [TimeW-1:0]        last_q;
  logic [SumW-1:0]         pts_q;
  logic [TimeW-1:0]        lt_q;

  // Accumulation.
  logic [TimeW-1:0]        delta_q;
  logic [SumW-1:0]         prod_q;
  logic [SumW:0]           sum_ext;
  logic [TimeW:0]          lt_ext;
  logic                    do_acc;

  // Slot memory and scan pipeline.
  otwmp_pkg::slot_t        mem [otwmp_pkg::MAX_ORDERS];
  otwmp_pkg::slot_t        rd_q;
  logic [SlotW:0]          addr_q;
  logic                    rd_en;
  logic                    cmp_vld_q;
  logic [SlotW-1:0]        cmp_idx_q;
  logic                    slot_live, match;
  logic [PriceW-1:0]       cand_upd, cand_del;
  logic                    hit_q, free_q;
  logic [SlotW-1:0]        hit_idx_q, free_idx_q;
  logic [PriceW-1:0]       max_upd_q, max_del_q;

  // Commit.
  logic                    wr_en;
  logic [SlotW-1:0]        wr_idx;
  otwmp_pkg::status_e      status_q, status_d;

  // Output register.
  logic                    out_valid_q;
  logic [otwmp_pkg::OUT_DATA_W-1:0] out_data_q;
  logic [1:0]              out_status_q;

  assign do_acc  = (count_q != '0) && (in_timestamp_i >= last_q);
  assign sum_ext = {1'b0, pts_q} + {1'b0, prod_q};
  assign lt_ext  = {1'b0, lt_q} + {1'b0, delta_q};

  assign rd_en     = cmd_i.scan && (addr_q != (SlotW + 1)'(otwmp_pkg::MAX_ORDERS));
  assign slot_live = valid_q[cmp_idx_q];
  assign match     = slot_live && (rd_q.id == id_q);
  // An updated order takes its new price; an erased one drops out.
  assign cand_upd  = match ? price_q : (slot_live ? rd_q.price : '0);
  assign cand_del  = (slot_live && !match) ? rd_q.price : '0;

  assign sts_o.scan_done = cmp_vld_q && (cmp_idx_q == SlotW'(otwmp_pkg::MAX_ORDERS - 1));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // Since max_q always equals the highest live price, the erase result is
  // the scan maximum over the remaining slots in every case.
  always_comb begin
    wr_en    = 1'b0;
    wr_idx   = hit_idx_q;
    valid_d  = valid_q;
    count_d  = count_q;
    max_d    = max_q;
    status_d = otwmp_pkg::ST_OK;
    if (command_q == otwmp_pkg::CMD_INSERT) begin
      if (hit_q) begin
        wr_en = cmd_i.commit;
        max_d = max_upd_q;
      end else if (free_q) begin
        wr_en           = cmd_i.commit;
        wr_idx          = free_idx_q;
        valid_d[free_idx_q] = 1'b1;
        count_d         = count_q + CntW'(1);
        max_d           = (price_q > max_q) ? price_q : max_q;
      end else begin
        status_d = otwmp_pkg::ST_FULL;
      end
    end else begin
      if (hit_q) begin
        valid_d[hit_idx_q] = 1'b0;
        count_d = count_q - CntW'(1);
        max_d   = max_del_q;
      end else begin
        status_d = otwmp_pkg::ST_UNKNOWN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      count_q     <= '0;
      max_q       <= '0;
      last_q      <= '0;
      pts_q       <= '0;
      lt_q        <= '0;
      addr_q      <= '0;
      cmp_vld_q   <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        addr_q <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end
      if (rd_en) begin
        addr_q <= addr_q + (SlotW + 1)'(1);
      end
      cmp_vld_q <= rd_en;
      if (cmp_vld_q) begin
        if (match) begin
          hit_q <= 1'b1;
        end
        if (!slot_live && !free_q) begin
          free_q <= 1'b1;
        end
      end
      if (cmd_i.acc) begin
        pts_q  <= sum_ext[SumW] ? '1 : sum_ext[SumW-1:0];
        lt_q   <= lt_ext[TimeW] ? '1 : lt_ext[TimeW-1:0];
        last_q <= ts_q;
      end
      if (cmd_i.commit) begin
        valid_q <= valid_d;
        count_q <= count_d;
        max_q   <= max_d;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      command_q <= otwmp_pkg::command_e'(in_command_i);
      ts_q      <= in_timestamp_i;
      id_q      <= in_order_id_i;
      price_q   <= in_price_i;
      delta_q   <= do_acc ? (in_timestamp_i - last_q) : '0;
      max_upd_q <= '0;
      max_del_q <= '0;
    end
    if (cmd_i.mul) begin
      prod_q <= SumW'(delta_q) * SumW'(max_q);
    end
    if (cmp_vld_q) begin
      if (match) begin
        hit_idx_q <= cmp_idx_q;
      end
      if (!slot_live && !free_q) begin
        free_idx_q <= cmp_idx_q;
      end
      if (cand_upd > max_upd_q) begin
        max_upd_q <= cand_upd;
      end
      if (cand_del > max_del_q) begin
        max_del_q <= cand_del;
      end
    end
    cmp_idx_q <= addr_q[SlotW-1:0];
    if (cmd_i.commit) begin
      status_q <= status_d;
    end
    if (cmd_i.load_out) begin
      out_data_q   <= {PadW'(0), lt_q, pts_q, max_q, (count_q != '0)};
      out_status_q <= status_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_idx] <= '{price: price_q, id: id_q};
    end
    if (rd_en) begin
      rd_q <= mem[addr_q[SlotW-1:0]];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_data_q;
  assign out_status_o = out_status_q;

  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(count_q))
    else $error("live count differs from the number of valid slots");

  a_empty_max_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (max_q == '0))
    else $error("highest price is nonzero with an empty book");

  a_sum_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pts_q >= $past(pts_q)) && (lt_q >= $past(lt_q)))
    else $error("accumulated sum or exposed time decreased");

endmodule

// ===== tb/price_book_monitor.sv =====
module price_book_monitor
  import otwmp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic [1:0]            m_axis_tuser,
  output int                    mismatches_o,
  output int                    waiting_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    status_e             status;
    logic                nonempty;
    logic [PRICE_W-1:0]  highest;
    logic [SUM_W-1:0]    wsum;
    logic [TIME_W-1:0]   exposed;
    logic [OUT_DATA_W-OUT_FIELD_W-1:0] pad;
  } book_view_t;

  book_view_t expected_views[$];

  // Shadow copy of the order table and the running sums.
  logic               live_q [MAX_ORDERS];
  logic [ID_W-1:0]    id_q   [MAX_ORDERS];
  logic [PRICE_W-1:0] price_q[MAX_ORDERS];
  logic [PRICE_W-1:0] top_price;
  logic [TIME_W-1:0]  last_stamp;
  logic [SUM_W-1:0]   price_ticks;
  logic [TIME_W-1:0]  busy_ticks;
  int                 live_orders;

  function automatic logic [PRICE_W-1:0] scan_top();
    logic [PRICE_W-1:0] best;
    best = '0;
    for (int i = 0; i < MAX_ORDERS; i++) begin
      if (live_q[i] && price_q[i] > best) best = price_q[i];
    end
    return best;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    book_view_t          seen;
    book_view_t          want;
    command_e            cmd;
    logic [TIME_W-1:0]   stamp;
    logic [ID_W-1:0]     oid;
    logic [PRICE_W-1:0]  price;
    logic [PRICE_W-1:0]  gone;
    logic [TIME_W-1:0]   delta;
    logic [SUM_W:0]      wide_sum;
    logic [TIME_W:0]     wide_time;
    int                  hit;
    int                  spot;
    logic                bad;

    if (!rst_ni) begin
      for (int i = 0; i < MAX_ORDERS; i++) begin
        live_q[i]  = 1'b0;
        id_q[i]    = '0;
        price_q[i] = '0;
      end
      top_price    = '0;
      last_stamp   = '0;
      price_ticks  = '0;
      busy_ticks   = '0;
      live_orders  = 0;
      mismatches_o = 0;
      expected_views.delete();
    end else begin
      // Results are matched before this edge's input is predicted, so a stray
      // result can never pair with an item accepted in the same cycle.
      if (m_axis_tvalid && m_axis_tready) begin
        seen.status   = status_e'(m_axis_tuser);
        seen.nonempty = m_axis_tdata[0];
        seen.highest  = m_axis_tdata[32:1];
        seen.wsum     = m_axis_tdata[96:33];
        seen.exposed  = m_axis_tdata[128:97];
        seen.pad      = m_axis_tdata[OUT_DATA_W-1:OUT_FIELD_W];
        if (expected_views.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= 10)
            $display("%0t: result item with nothing expected: status=%0d highest=%h",
                     $realtime, seen.status, seen.highest);
        end else begin
          want = expected_views.pop_front();
          bad = (seen.status != want.status) || (seen.nonempty != want.nonempty) ||
                (seen.highest != want.highest) || (seen.wsum != want.wsum) ||
                (seen.exposed != want.exposed) || (seen.pad != want.pad);
          if (bad) begin
            mismatches_o++;
            if (mismatches_o <= 10) begin
              $display("%0t: expected status=%0d live=%0b high=%h sum=%h exp=%h pad=%h",
                       $realtime, want.status, want.nonempty, want.highest, want.wsum,
                       want.exposed, want.pad);
              $display("%0t:      got status=%0d live=%0b high=%h sum=%h exp=%h pad=%h",
                       $realtime, seen.status, seen.nonempty, seen.highest, seen.wsum,
                       seen.exposed, seen.pad);
            end
          end
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        cmd   = command_e'(s_axis_tuser);
        stamp = s_axis_tdata[31:0];
        oid   = s_axis_tdata[63:32];
        price = s_axis_tdata[95:64];
        want.status = ST_OK;

        // Time only counts while the book holds an order; a step back in time
        // adds nothing but still moves the reference point.
        if (live_orders > 0 && stamp >= last_stamp) begin
          delta       = stamp - last_stamp;
          wide_sum    = {1'b0, price_ticks} + {1'b0, 64'(delta) * 64'(top_price)};
          price_ticks = wide_sum[SUM_W] ? '1 : wide_sum[SUM_W-1:0];
          wide_time   = {1'b0, busy_ticks} + {1'b0, delta};
          busy_ticks  = wide_time[TIME_W] ? '1 : wide_time[TIME_W-1:0];
        end
        last_stamp = stamp;

        hit = -1;
        for (int i = 0; i < MAX_ORDERS; i++) begin
          if (hit < 0 && live_q[i] && id_q[i] == oid) hit = i;
        end

        if (cmd == CMD_INSERT) begin
          if (hit >= 0) begin
            price_q[hit] = price;
            top_price    = scan_top();
          end else begin
            spot = -1;
            for (int i = 0; i < MAX_ORDERS; i++) begin
              if (spot < 0 && !live_q[i]) spot = i;
            end
            if (spot < 0) begin
              want.status = ST_FULL;
            end else begin
              live_q[spot]  = 1'b1;
              id_q[spot]    = oid;
              price_q[spot] = price;
              live_orders++;
              if (price > top_price) top_price = price;
            end
          end
        end else if (hit < 0) begin
          want.status = ST_UNKNOWN;
        end else begin
          gone        = price_q[hit];
          live_q[hit] = 1'b0;
          live_orders--;
          if (gone >= top_price) top_price = scan_top();
        end

        want.nonempty = (live_orders > 0);
        want.highest  = top_price;
        want.wsum     = price_ticks;
        want.exposed  = busy_ticks;
        want.pad      = '0;
        expected_views.push_back(want);
      end
    end
    waiting_o = expected_views.size();
  end

endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import otwmp_pkg::*;

  localparam int POOL_SIZE     = 96;
  localparam int SEGMENTS      = 16;
  localparam int SEGMENT_ITEMS = 88;

  typedef enum int {
    PACE_FREE,
    PACE_SENDER,
    PACE_RECEIVER,
    PACE_BOTH
  } pace_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0]            m_axis_tuser;

  int                    mismatches;
  int                    waiting;
  int                    idle_pct  = 0;
  int                    stall_pct = 0;
  logic [ID_W-1:0]       id_pool[POOL_SIZE];
  logic [TIME_W-1:0]     clock_ticks;

  order_table_time_weighted_max_price_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  price_book_monitor monitor (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .mismatches_o  (mismatches),
    .waiting_o     (waiting)
  );

  always #1 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic set_pacing(input pace_e mode);
    case (mode)
      PACE_FREE: begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      PACE_SENDER: begin
        idle_pct  = 61;
        stall_pct = 0;
      end
      PACE_RECEIVER: begin
        idle_pct  = 0;
        stall_pct = 61;
      end
      default: begin
        idle_pct  = 18;
        stall_pct = 18;
      end
    endcase
  endtask

  // Returns at the rising edge where the item was taken; tvalid stays high
  // into the next item unless the sender decides to idle.
  task automatic send_order(input command_e cmd, input logic [TIME_W-1:0] stamp,
                            input logic [ID_W-1:0] oid, input logic [PRICE_W-1:0] price);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {price, oid, stamp};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (waiting != 0) @(negedge clk_i);
  endtask

  task automatic random_order(input int insert_pct);
    command_e           cmd;
    logic [ID_W-1:0]    oid;
    logic [PRICE_W-1:0] price;
    int                 pick;
    cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_ERASE;
    oid = id_pool[$urandom_range(0, POOL_SIZE - 1)];
    // Stray ids are only erased, so they never pile up in the table.
    if (cmd == CMD_ERASE && $urandom_range(0, 99) < 10) oid = $urandom;
    if ($urandom_range(0, 99) < 15) price = 32'h0001_0000 << $urandom_range(0, 15);
    else price = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 3) clock_ticks = clock_ticks - $urandom_range(0, clock_ticks);
    else if (pick >= 15) clock_ticks = clock_ticks + $urandom_range(1, 1000);
    send_order(cmd, clock_ticks, oid, price);
  endtask

  initial begin
    logic [31:0] seed;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    clock_ticks   = '0;
    for (int k = 0; k < POOL_SIZE; k++) begin
      seed       = $urandom;
      id_pool[k] = {seed[31:7], 7'(k)};
    end
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: extremes, backwards time, updates, ties and erases.
    send_order(CMD_ERASE,  32'd0,        32'd0,        32'd0);
    send_order(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_order(CMD_INSERT, 32'd0,        32'd0,        32'd0);
    send_order(CMD_INSERT, 32'd10,       32'd5,        32'h0001_0000);
    send_order(CMD_INSERT, 32'd12,       32'hFFFF_FFFF, 32'h0000_0100);
    send_order(CMD_INSERT, 32'd12,       32'd0,        32'h0002_0000);
    send_order(CMD_ERASE,  32'd20,       32'd0,        32'hFFFF_FFFF);
    send_order(CMD_INSERT, 32'd21,       32'd7,        32'h0000_8000);
    send_order(CMD_ERASE,  32'd25,       32'd7,        32'd0);
    send_order(CMD_INSERT, 32'd26,       32'd8,        32'h0001_0000);
    send_order(CMD_ERASE,  32'd27,       32'd5,        32'd0);
    send_order(CMD_ERASE,  32'd30,       32'h0000_1234, 32'd0);
    send_order(CMD_ERASE,  32'd31,       32'd8,        32'd0);
    send_order(CMD_ERASE,  32'd40,       32'hFFFF_FFFF, 32'd0);
    send_order(CMD_INSERT, 32'd45,       32'd9,        32'd0);
    send_order(CMD_INSERT, 32'd50,       32'd10,       32'hAAAA_5555);
    send_order(CMD_ERASE,  32'd50,       32'd9,        32'd0);
    send_order(CMD_ERASE,  32'd60,       32'd10,       32'd0);
    clock_ticks = 32'd60;
    drain();

    // Fill the table past capacity, update while full, then reuse a freed slot.
    for (int k = 0; k < 70; k++) begin
      clock_ticks = clock_ticks + 1;
      send_order(CMD_INSERT, clock_ticks, id_pool[k], $urandom);
    end
    send_order(CMD_INSERT, clock_ticks, id_pool[0], $urandom);
    send_order(CMD_ERASE, clock_ticks, id_pool[3], $urandom);
    send_order(CMD_INSERT, clock_ticks, id_pool[80], $urandom);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      set_pacing(pace_e'(seg % 4));
      for (int i = 0; i < SEGMENT_ITEMS; i++) begin
        random_order((seg % 3 == 0) ? 80 : (seg % 3 == 1) ? 50 : 20);
      end
      if (seg % 5 == 0) drain();
    end

    // Empty the book, then drive both sums into saturation.
    for (int k = 0; k < POOL_SIZE; k++) begin
      clock_ticks = clock_ticks + $urandom_range(0, 50);
      send_order(CMD_ERASE, clock_ticks, id_pool[k], $urandom);
    end
    send_order(CMD_INSERT, 32'd0,         32'h0000_0077, 32'hFFFF_FFFF);
    send_order(CMD_INSERT, 32'hFFFF_FFFF, 32'h0000_0078, 32'd1);
    send_order(CMD_INSERT, 32'd0,         32'h0000_0078, 32'd2);
    send_order(CMD_ERASE,  32'hFFFF_FFFF, 32'h0000_0078, 32'd0);
    send_order(CMD_INSERT, 32'hFFFF_FFFF, 32'h0000_0077, 32'h7FFF_FFFF);
    send_order(CMD_INSERT, 32'd5,         32'h0000_0079, 32'd3);
    send_order(CMD_ERASE,  32'd9,         32'h0000_0077, 32'd0);
    send_order(CMD_ERASE,  32'd9,         32'h0000_0079, 32'd0);

    drain();
    repeat (100) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/otwmp_pkg.sv
src/otwmp_ctrl.sv
src/otwmp_dp.sv
src/order_table_time_weighted_max_price_core.sv
tb/price_book_monitor.sv
tb/testbench.sv
